### sv/emboss_pkg.sv
// Package for the diagonal 3x3 emboss filter.
// Holds the pixel and result request types, register indexes and filter constants.
// No dependencies.
package emboss_pkg;

  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 3 * CHAN_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int FW_W       = 12;
  localparam int FH_W       = 13;
  localparam int ROW_W      = 12;

  localparam logic [FW_W-1:0] FW_RESET  = 12'd640;
  localparam logic [FH_W-1:0] FH_RESET  = 13'd480;
  localparam logic [FH_W-1:0] FH_MAX    = 13'd4096;
  localparam logic [CHAN_W:0] EMB_BIAS  = 9'd100;
  localparam logic [CHAN_W-1:0] PIX_MAX = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] in_blue;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_red;
    logic              frame_start;
  } pixel_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_red;
    logic              frame_last;
  } pixel_out_t;

  typedef struct packed {
    logic emit;
    logic last;
  } pos_flags_t;

endpackage

### sv/emboss_lane.sv
// One channel lane of the emboss filter: upper-left minus lower-right plus bias, clamped.
// Depends on emboss_pkg.
module emboss_lane (
  input  logic [emboss_pkg::CHAN_W-1:0] ul,
  input  logic [emboss_pkg::CHAN_W-1:0] lr,
  output logic [emboss_pkg::CHAN_W-1:0] res
);
  import emboss_pkg::*;

  logic signed [CHAN_W+1:0] diff;

  assign diff = $signed({2'b00, ul}) - $signed({2'b00, lr}) + $signed({1'b0, EMB_BIAS});

  always_comb begin
    if (diff < 0) begin
      res = '0;
    end else if (diff > $signed({2'b00, PIX_MAX})) begin
      res = PIX_MAX;
    end else begin
      res = diff[CHAN_W-1:0];
    end
  end

endmodule

### sv/emboss_raster.sv
// Raster position tracker: column and row counters with frame-start resync and wrap.
// Depends on emboss_pkg; gives the line store address and result flags per request.
module emboss_raster #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          frame_start,
  input  logic [emboss_pkg::FW_W-1:0]   frame_width,
  input  logic [emboss_pkg::FH_W-1:0]   frame_height,
  output logic [$clog2(MAX_WIDTH):0]    addr,
  output emboss_pkg::pos_flags_t        flags
);
  import emboss_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = CW + FW_W + 1;
  localparam logic [EW-1:0] WMAX = EW'(MAX_WIDTH);

  logic [CW-1:0]    col;
  logic [CW-1:0]    col_next;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] row_next;
  logic [EW-1:0]    w;
  logic [FH_W-1:0]  h;
  logic [EW-1:0]    c0;
  logic [EW-1:0]    c1;
  logic [EW-1:0]    c2;
  logic [FH_W-1:0]  r0;
  logic [FH_W-1:0]  r1;
  logic [FH_W-1:0]  r2;
  logic [FH_W-1:0]  r3;

  always_comb begin
    w = EW'(frame_width);
    if (w < EW'(3)) w = EW'(3);
    if (w > WMAX) w = WMAX;
    h = frame_height;
    if (h < FH_W'(3)) h = FH_W'(3);
    if (h > FH_MAX) h = FH_MAX;

    c0 = frame_start ? '0 : EW'(col);
    r0 = frame_start ? '0 : FH_W'(row);
    if (c0 >= w) begin
      c1 = '0;
      r1 = r0 + FH_W'(1);
    end else begin
      c1 = c0;
      r1 = r0;
    end
    r2 = (r1 >= h) ? '0 : r1;

    c2 = c1 + EW'(1);
    if (c2 >= w) begin
      col_next = '0;
      r3       = r2 + FH_W'(1);
      if (r3 >= h) r3 = '0;
    end else begin
      col_next = c2[CW-1:0];
      r3       = r2;
    end
    row_next = r3[ROW_W-1:0];

    addr       = {r2[0], c1[CW-1:0]};
    flags.emit = (r2 >= FH_W'(2)) && (c1 >= EW'(2));
    flags.last = (r2 == h - FH_W'(1)) && (c1 == w - EW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (advance) begin
      col <= col_next;
      row <= row_next;
    end
  end

  frame_start_resync: assert property (@(posedge clk) disable iff (rst)
    advance && frame_start |=> col == CW'(1) && row == '0)
    else $error("counters not resynced on frame start");

endmodule

### sv/emboss_line_buf.sv
// Two-row line store with registered read-before-write port and the two-pixel delay.
// Depends on emboss_pkg; supplies the upper-left neighbor for each request.
module emboss_line_buf #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_WIDTH):0]   addr,
  input  logic [emboss_pkg::PIX_W-1:0] wdata,
  input  logic                         shift,
  output logic [emboss_pkg::PIX_W-1:0] ul
);
  import emboss_pkg::*;

  localparam int DEPTH = 2 ** ($clog2(MAX_WIDTH) + 1);

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata;
  logic [PIX_W-1:0] dly0;
  logic [PIX_W-1:0] dly1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rdata     <= mem[addr];
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      dly1 <= dly0;
      dly0 <= rdata;
    end
  end

  assign ul = dly1;

endmodule

### sv/emboss_diagonal_3x3_filter.sv
// Diagonal 3x3 emboss filter, top level.
// Usage: BGR pixels enter in raster order on the pixel channel (pixel_valid,
// pixel_stall, pixel); frame_start marks row 0, column 0 and resyncs the counters.
// Each interior pixel yields one result on the result channel (result_valid,
// result_stall, result) when its lower-right neighbor arrives; border rows and
// columns give nothing. frame_last flags the last interior result of a frame.
// Throughput: one pixel per cycle while the receiver does not stall, set by
// the single-port line store that is read and written once per request. The
// read stage registers the completing pixel, then the output register its result.
// When the receiver stalls, the output register holds, one more pixel moves into
// an empty read stage, and then pixel_stall rises until the result is taken.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data write frame_width (0) and
// frame_height (1); cfg_ready is always high. Write only while the block is idle.
// Reset: counters go to row 0, column 0, width 640, height 480, pipeline empty;
// the line store keeps no reset and is filled by the first two rows of a frame.
// Depends on emboss_pkg, emboss_raster, emboss_line_buf, emboss_lane.
module emboss_diagonal_3x3_filter #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pixel_valid,
  output logic                              pixel_stall,
  input  emboss_pkg::pixel_in_t             pixel,
  output logic                              result_valid,
  input  logic                              result_stall,
  output emboss_pkg::pixel_out_t            result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [emboss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [emboss_pkg::CFG_DATA_W-1:0] cfg_data
);
  import emboss_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH) + 1;

  logic [FW_W-1:0]  frame_width;
  logic [FH_W-1:0]  frame_height;
  logic             accept;
  logic             out_ready;
  logic             s1_adv;
  logic             s1_valid;
  logic [PIX_W-1:0] s1_cur;
  pos_flags_t       s1_pos;
  logic [AW-1:0]    addr;
  pos_flags_t       flags;
  logic [PIX_W-1:0] cur;
  logic [PIX_W-1:0] ul;
  logic [PIX_W-1:0] lane_res;

  assign cfg_ready   = 1'b1;
  assign out_ready   = !result_valid || !result_stall;
  assign s1_adv      = s1_valid && out_ready;
  assign pixel_stall = s1_valid && !out_ready;
  assign accept      = pixel_valid && !pixel_stall;
  assign cur         = {pixel.in_red, pixel.in_green, pixel.in_blue};

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_RESET;
      frame_height <= FH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default:          frame_width  <= frame_width;
      endcase
    end
  end

  emboss_raster #(.MAX_WIDTH(MAX_WIDTH)) u_raster (
    .clk          (clk),
    .rst          (rst),
    .advance      (accept),
    .frame_start  (pixel.frame_start),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .addr         (addr),
    .flags        (flags)
  );

  emboss_line_buf #(.MAX_WIDTH(MAX_WIDTH)) u_line_buf (
    .clk   (clk),
    .wr_en (accept),
    .addr  (addr),
    .wdata (cur),
    .shift (s1_adv),
    .ul    (ul)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    emboss_lane u_lane (
      .ul  (ul[i*CHAN_W +: CHAN_W]),
      .lr  (s1_cur[i*CHAN_W +: CHAN_W]),
      .res (lane_res[i*CHAN_W +: CHAN_W])
    );
  end

  // read stage: hold the request while its line store data is registered
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur <= cur;
      s1_pos <= flags;
    end
  end

  // merge lanes into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_ready) begin
      result_valid <= s1_adv && s1_pos.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      result.out_blue   <= lane_res[0 +: CHAN_W];
      result.out_green  <= lane_res[CHAN_W +: CHAN_W];
      result.out_red    <= lane_res[2*CHAN_W +: CHAN_W];
      result.frame_last <= s1_pos.last;
    end
  end

  stall_needs_pending: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> s1_valid)
    else $error("pixel stalled with empty read stage");

  accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted request lost before read stage");

  last_is_interior: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_pos.last |-> s1_pos.emit)
    else $error("frame_last on a border pixel");

endmodule
